@@ hw/rtl/dct_pkg.sv @@
// Package for the 8x8 2D DCT core: shared widths, cosine table, cell control struct.
// No dependencies.
package dct_pkg;

    localparam int SampleW = 8;
    localparam int MidW    = 20;
    localparam int CosW    = 15;
    localparam int CoefW   = 14;
    localparam int IdxW    = 6;
    localparam int AccW    = 40;

    // cycles from the last MAC issue of a pass until its last result is stored
    localparam logic [3:0] DrainLast = 4'd10;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_ROW,
        ST_COL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       clear;
        logic       mac;
        logic [2:0] k;
        logic [2:0] line;
    } t_cell_ctl;

    function automatic logic signed [CosW-1:0] cos_q14(input logic [2:0] r, input logic [2:0] c);
        logic [5:0] idx;
        logic signed [CosW-1:0] v;
        idx = {r, c};
        case (idx)
            6'd0,6'd1,6'd2,6'd3,6'd4,6'd5,6'd6,6'd7: v = 15'sd5793;
            6'd8:  v = 15'sd8035;  6'd9:  v = 15'sd6811;  6'd10: v = 15'sd4551;
            6'd11: v = 15'sd1598;  6'd12: v = -15'sd1598; 6'd13: v = -15'sd4551;
            6'd14: v = -15'sd6811; 6'd15: v = -15'sd8035;
            6'd16: v = 15'sd7568;  6'd17: v = 15'sd3135;  6'd18: v = -15'sd3135;
            6'd19: v = -15'sd7568; 6'd20: v = -15'sd7568; 6'd21: v = -15'sd3135;
            6'd22: v = 15'sd3135;  6'd23: v = 15'sd7568;
            6'd24: v = 15'sd6811;  6'd25: v = -15'sd1598; 6'd26: v = -15'sd8035;
            6'd27: v = -15'sd4551; 6'd28: v = 15'sd4551;  6'd29: v = 15'sd8035;
            6'd30: v = 15'sd1598;  6'd31: v = -15'sd6811;
            6'd32: v = 15'sd5793;  6'd33: v = -15'sd5793; 6'd34: v = -15'sd5793;
            6'd35: v = 15'sd5793;  6'd36: v = 15'sd5793;  6'd37: v = -15'sd5793;
            6'd38: v = -15'sd5793; 6'd39: v = 15'sd5793;
            6'd40: v = 15'sd4551;  6'd41: v = -15'sd8035; 6'd42: v = 15'sd1598;
            6'd43: v = 15'sd6811;  6'd44: v = -15'sd6811; 6'd45: v = -15'sd1598;
            6'd46: v = 15'sd8035;  6'd47: v = -15'sd4551;
            6'd48: v = 15'sd3135;  6'd49: v = -15'sd7568; 6'd50: v = 15'sd7568;
            6'd51: v = -15'sd3135; 6'd52: v = -15'sd3135; 6'd53: v = 15'sd7568;
            6'd54: v = -15'sd7568; 6'd55: v = 15'sd3135;
            6'd56: v = 15'sd1598;  6'd57: v = -15'sd4551; 6'd58: v = 15'sd6811;
            6'd59: v = -15'sd8035; 6'd60: v = 15'sd8035;  6'd61: v = -15'sd6811;
            6'd62: v = 15'sd4551;  6'd63: v = -15'sd1598;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/dct_mac_cell.sv @@
// One MAC cell of the DCT chain: multiplies its operand by its cosine term and accumulates.
// Depends on dct_pkg. Operand and control enter on i_x/i_ctl and are registered before they pass to the next cell.
module dct_mac_cell import dct_pkg::*; #(
    parameter logic [2:0] COL = 3'd0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic signed [MidW-1:0] i_x,
    output logic signed [MidW-1:0] o_x,
    output t_cell_ctl              o_ctl,
    output logic signed [AccW-1:0] o_acc
);
    logic signed [MidW-1:0] r_x;
    t_cell_ctl              r_ctl;
    logic signed [AccW-1:0] r_acc;
    logic signed [CosW-1:0] w_c;
    logic signed [MidW+CosW-1:0] w_p;

    // both passes use T[COL][k]: the row pass gives W[i][COL], the column pass Y[COL][v]
    assign w_c = cos_q14(COL, i_ctl.k);
    assign w_p = i_x * w_c;

    always_ff @(posedge i_clk) begin
        r_x <= i_x;
        if (i_ctl.mac) begin
            r_acc <= (i_ctl.clear ? AccW'(0) : r_acc) + AccW'(w_p);
        end
    end

    // r_ctl is the last cycle's control; when its mac bit is set, r_acc holds that MAC's sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_x   = r_x;
    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
endmodule

@@ hw/rtl/dct_8x8_2d_core.sv @@
// Top level of the 8x8 2D DCT core: sample store, transpose store, MAC chain, output stage.
// Depends on dct_pkg and dct_mac_cell.
//
// The block takes 64 signed samples of an 8x8 block in row-major order (at most one per
// cycle while filling), then computes Y = T*X*T' with a chain of eight MAC cells. One
// operand per cycle is read from a store and walks down the chain together with its
// control, one cell per cycle; cell j multiplies by T[j][k]. The row pass streams X row by
// row and cell j forms W[i][j]; the column pass streams W column by column and cell u forms
// Y[u][v]. Cells finish a line one after another, so one result per cycle is rounded and
// written back. Each pass issues 64 operands back to back, then drains the chain (store
// read, eight chain stages, write-back register). The 64 coefficients then leave one per
// accepted transaction, row-major, with tlast on the last; the first is read from the
// store into the output register before it is offered. Input is not accepted after the 64th
// sample until the last coefficient is taken, so throughput is set by the single operand
// stream into the eight shared multipliers and by the phases not overlapping. Coefficients
// are Q(13-OUT_FRAC_BITS).OUT_FRAC_BITS, rounded half up and saturated to 14 bits.
module dct_8x8_2d_core import dct_pkg::*; #(
    parameter int OUT_FRAC_BITS = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] sample
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [13:0] coefficient, [19:14] coef_index
    output logic             m_axis_tlast    // last_coef
);
    localparam int ColShift = 24 - OUT_FRAC_BITS;

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;       // fill index / issue step / output read index
    logic [3:0] r_drain, n_drain;   // cycles after the last issue of a pass

    logic signed [SampleW-1:0] r_samp [64];
    logic signed [MidW-1:0]    r_tr   [64];
    logic signed [CoefW-1:0]   r_out  [64];

    // registered store reads and the control that goes with them
    logic signed [SampleW-1:0] r_samp_q;
    logic signed [MidW-1:0]    r_tr_q;
    t_cell_ctl                 r_ctl0;
    logic                      r_feed_col;

    t_cell_ctl w_ctl;
    logic w_col;
    logic w_load;
    logic signed [MidW-1:0] w_x [9];
    t_cell_ctl              w_cc [9];
    logic signed [AccW-1:0] w_acc [8];

    // finished line results, one cell at a time
    logic [7:0]             w_done;
    logic                   w_hit;
    logic [2:0]             w_hit_cell;
    logic [2:0]             w_hit_line;
    logic signed [AccW-1:0] w_hit_acc;
    logic                   r_wb_en;
    logic [2:0]             r_wb_cell;
    logic [2:0]             r_wb_line;
    logic signed [AccW-1:0] r_wb_acc;

    // output register, loaded straight from the coefficient store
    logic                   r_ovld;
    logic signed [CoefW-1:0] r_ocoef;
    logic [IdxW-1:0]        r_oidx;
    logic                   r_olast;

    assign w_col = (r_state == ST_COL);

    // chain head: X[i][k] on the row pass, W[k][v] on the column pass
    assign w_x[0]  = r_feed_col ? r_tr_q : MidW'(r_samp_q);
    assign w_cc[0] = r_ctl0;

    genvar g;
    generate
        for (g = 0; g < 8; g++) begin : g_cell
            dct_mac_cell #(.COL(3'(g))) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cc[g]),
                .i_x     (w_x[g]),
                .o_x     (w_x[g+1]),
                .o_ctl   (w_cc[g+1]),
                .o_acc   (w_acc[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_drain = r_drain;
        w_ctl   = '0;
        w_load  = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_FILL: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        n_state = ST_ROW;
                        n_cnt   = '0;
                        n_drain = '0;
                    end
                end
            end
            ST_ROW, ST_COL: begin
                // issue 64 operands back to back, then drain the chain
                if (r_drain == 4'd0) begin
                    w_ctl.mac   = 1'b1;
                    w_ctl.clear = (r_cnt[2:0] == 3'd0);
                    w_ctl.k     = r_cnt[2:0];
                    w_ctl.line  = r_cnt[5:3];
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd63) n_drain = 4'd1;
                end else if (r_drain == DrainLast) begin
                    n_drain = '0;
                    n_cnt   = '0;
                    n_state = w_col ? ST_EMIT : ST_COL;
                end else begin
                    n_drain = r_drain + 4'd1;
                end
            end
            ST_EMIT: begin
                // load the next coefficient when the output register frees up
                w_load = !(r_ovld && r_olast) && (!r_ovld || m_axis_tready);
                if (w_load) n_cnt = r_cnt + 6'd1;
                if (r_ovld && r_olast && m_axis_tready) n_state = ST_FILL;
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_cnt   <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0     <= '0;
            r_feed_col <= 1'b0;
        end else begin
            r_ctl0     <= w_ctl;
            r_feed_col <= w_col;
        end
    end

    // cells finish a line one after another; pick the one that just did
    always_comb begin
        w_hit      = 1'b0;
        w_hit_cell = '0;
        w_hit_line = '0;
        w_hit_acc  = '0;
        for (int j = 0; j < 8; j++) begin
            w_done[j] = w_cc[j+1].mac && (w_cc[j+1].k == 3'd7);
            if (w_done[j]) begin
                w_hit      = 1'b1;
                w_hit_cell = 3'(j);
                w_hit_line = w_cc[j+1].line;
                w_hit_acc  = w_acc[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_en <= 1'b0;
        end else begin
            r_wb_en <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_cell <= w_hit_cell;
        r_wb_line <= w_hit_line;
        r_wb_acc  <= w_hit_acc;
    end

    // rounding of the accumulators, with saturation on the output coefficients
    function automatic logic signed [MidW-1:0] rnd_mid(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] t;
        t = (a + AccW'(8)) >>> 4;
        return t[MidW-1:0];
    endfunction

    function automatic logic signed [CoefW-1:0] rnd_out(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] t;
        t = (a + (AccW'(1) <<< (ColShift - 1))) >>> ColShift;
        if (t > AccW'(8191)) return 14'sd8191;
        if (t < -AccW'(8192)) return -14'sd8192;
        return t[CoefW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_samp[r_cnt] <= $signed(s_axis_tdata);
        end
        r_samp_q <= r_samp[r_cnt];
    end

    // W[i][j] stored row-major; read column by column on the column pass
    always_ff @(posedge i_clk) begin
        if (r_wb_en && !w_col) begin
            r_tr[{r_wb_line, r_wb_cell}] <= rnd_mid(r_wb_acc);
        end
        r_tr_q <= r_tr[{r_cnt[2:0], r_cnt[5:3]}];
    end

    // cell u on column line v gives Y[u][v]
    always_ff @(posedge i_clk) begin
        if (r_wb_en && w_col) begin
            r_out[{r_wb_cell, r_wb_line}] <= rnd_out(r_wb_acc);
        end
        if (w_load) begin
            r_ocoef <= r_out[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld  <= 1'b0;
            r_oidx  <= '0;
            r_olast <= 1'b0;
        end else if (w_load) begin
            r_ovld  <= 1'b1;
            r_oidx  <= r_cnt;
            r_olast <= (r_cnt == 6'd63);
        end else if (m_axis_tready) begin
            r_ovld  <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {4'd0, r_oidx, r_ocoef};
    assign m_axis_tlast  = r_olast;

    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FILL) |-> !s_axis_tready) else $error("input taken while busy");
    a_emit_after_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_EMIT) |-> $past(r_state) == ST_COL) else $error("bad emit entry");
    a_fill_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> r_state == ST_FILL)
        else $error("no return to fill");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output changed while stalled");
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done)) else $error("two cells finished in one cycle");
    a_chain_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cc[8].mac |-> !$isunknown(w_x[8])) else $error("unknown operand at chain end");
endmodule

@@ sim/dct_8x8_2d_core_tb.sv @@
// Testbench for dct_8x8_2d_core: streams 8x8 sample blocks and checks every coefficient.
// Depends on dct_pkg and the core RTL; the expected coefficients come from a local fixed-point model.
module dct_8x8_2d_core_tb import dct_pkg::*; ();

    localparam int FracBits  = 3;
    localparam int StallMax  = 40;
    localparam int IdleLimit = 20000;
    localparam int NumItems  = 384;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;      // [7:0] sample
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [13:0] coefficient, [19:14] coef_index
    logic m_axis_tlast;                 // last_coef

    typedef struct packed {
        logic signed [CoefW-1:0] coef;
        logic [IdxW-1:0]         idx;
        logic                    last;
    } t_coef;

    logic [7:0]  sample_q[$];
    t_coef       coef_q[$];
    int          errors = 0;
    bit          hold_off = 0;
    int          idle_cycles = 0;
    int          n_acc = 0;

    // Local model state: samples of the current block and their count.
    logic signed [7:0] blk[64];
    int                blk_fill = 0;

    dct_8x8_2d_core #(.OUT_FRAC_BITS(FracBits)) dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic int fold_cos(int m);
        // m is (2c+1)r mod 32; cos(m*pi/16)
        int mag[9] = '{8192, 8035, 7568, 6811, 5793, 4551, 3135, 1598, 0};
        int a;
        int sgn;
        a = m;
        sgn = 1;
        if (a > 16) a = 32 - a;
        if (a > 8) begin
            a = 16 - a;
            sgn = -1;
        end
        return sgn * mag[a];
    endfunction

    // Cosine matrix T in Q1.14, written out independently of the package.
    function automatic int cos_tab(int r, int c);
        if (r == 0) return 5793;
        return fold_cos(((2 * c + 1) * r) % 32);
    endfunction

    function automatic longint rnd_floor(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Add one sample; after the 64th, queue the 64 expected coefficients.
    task automatic predict_sample(logic [7:0] d);
        longint w[64];
        longint acc;
        longint r;
        t_coef e;
        blk[blk_fill] = d;
        blk_fill++;
        if (blk_fill < 64) return;
        blk_fill = 0;
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++) begin
                acc = 0;
                for (int k = 0; k < 8; k++) acc += longint'(blk[i*8+k]) * cos_tab(j, k);
                w[i*8+j] = rnd_floor(acc, 4);
            end
        for (int u = 0; u < 8; u++)
            for (int v = 0; v < 8; v++) begin
                acc = 0;
                for (int i = 0; i < 8; i++) acc += longint'(cos_tab(u, i)) * w[i*8+v];
                r = rnd_floor(acc, 24 - FracBits);
                if (r > 8191) r = 8191;
                if (r < -8192) r = -8192;
                e.coef = r[CoefW-1:0];
                e.idx = IdxW'(u * 8 + v);
                e.last = (u * 8 + v == 63);
                coef_q.push_back(e);
            end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, StallMax);
    endfunction

    // Driver: offer queued samples, with random gaps; predict on each accepted transaction.
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sample(s_axis_tdata);
                n_acc++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    s_axis_tdata <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    drv_gap <= gap_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random ready, plus a long hold-off; check each coefficient transaction.
    always @(posedge i_clk) begin
        t_coef e;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (coef_q.size() == 0) begin
                    $display("%0t: unexpected coefficient %h last %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    e = coef_q.pop_front();
                    if (m_axis_tdata[13:0] !== e.coef || m_axis_tdata[19:14] !== e.idx
                        || m_axis_tdata[23:20] !== 4'd0 || m_axis_tlast !== e.last) begin
                        $display("%0t: expected coef %0d idx %0d last %b, got %0d idx %0d last %b",
                                 $time, e.coef, e.idx, e.last, $signed(m_axis_tdata[13:0]),
                                 m_axis_tdata[19:14], m_axis_tlast);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !hold_off && (gap_len() == 0 || $urandom_range(0, 1));
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_block(int kind);
        for (int n = 0; n < 64; n++)
            case (kind)
                0: sample_q.push_back(8'h7f);
                1: sample_q.push_back(8'h80);
                2: sample_q.push_back(n[0] ^ n[3] ? 8'h80 : 8'h7f);
                default: sample_q.push_back(8'($urandom_range(0, 255)));
            endcase
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: full-scale positive, full-scale negative, checkerboard of extremes.
        push_block(0);
        push_block(1);
        push_block(2);
        // One random block, then two more under a long hold-off: 384 samples in all.
        push_block(3);
        wait (n_acc == 256 && coef_q.size() == 0);
        // Long receiver hold-off while the sender fills a block and keeps offering the next.
        hold_off = 1;
        push_block(3);
        push_block(3);
        repeat (600) @(posedge i_clk);
        hold_off = 0;
        wait (n_acc == NumItems);
        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && coef_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
